/* rtl/krr_pkg.sv */
// ----------------------------------------------------------------------------
// krr_pkg
// Shared types and constants of the key repeat and release debouncer.
// ----------------------------------------------------------------------------
package krr_pkg;

   // field widths
   localparam int KEY_W      = 25;
   localparam int DELAY_W    = 16;
   localparam int COUNT_W    = 3;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [DELAY_W-1:0] RESET_DELAY = 16'd200;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_DELAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CODE_0    = 3'd2;

   // input word kinds; code 3 is dropped at the front
   typedef enum logic [CMD_W-1:0] {
      CMD_PRESS   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TICK    = 2'd2
   } cmd_type;

   // per-slot phase
   typedef enum logic [1:0] {
      PH_ABSENT  = 2'd0,
      PH_HELD    = 2'd1,
      PH_PENDING = 2'd2
   } phase_type;

   // back end sequencer
   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WALK = 1'b1
   } back_state_type;

   // one result word
   typedef struct packed {
      logic             report_press;
      logic             report_release;
      logic [KEY_W-1:0] event_key;
      logic             eaten;
      logic             last;
   } rsp_type;

endpackage

/* rtl/krr_csr.sv */
// ----------------------------------------------------------------------------
// krr_csr
// Configuration registers: release delay, key count and the key code table.
// ----------------------------------------------------------------------------
module krr_csr
   import krr_pkg::*;
#(
   parameter int KEY_SLOTS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [DELAY_W-1:0]    release_delay,
   output logic [COUNT_W-1:0]    key_count,
   output logic [KEY_W-1:0]      key_codes [KEY_SLOTS]
);

   logic [DELAY_W-1:0]   delay_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [KEY_W-1:0]     code_ff [KEY_SLOTS];
   logic [CSR_IDX_W-1:0] code_idx;

   // key code registers sit from CSR_KEY_CODE_0 upward
   assign code_idx = csr_index - CSR_KEY_CODE_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= RESET_DELAY;
         count_ff <= '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            code_ff[i] <= '0;
         end
      end else if (csr_we) begin
         priority case (csr_index)
            CSR_RELEASE_DELAY: delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_KEY_COUNT:     count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  if (code_idx == CSR_IDX_W'(i)) begin
                     code_ff[i] <= csr_wdata[KEY_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   assign release_delay = delay_ff;
   assign key_count     = count_ff;

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         key_codes[i] = code_ff[i];
      end
   end

endmodule

/* rtl/krr_front.sv */
// ----------------------------------------------------------------------------
// krr_front
// Takes input words, looks the key up in the code table and holds the
// classified word until the queue has room.
// ----------------------------------------------------------------------------
module krr_front
   import krr_pkg::*;
#(
   parameter int KEY_SLOTS = 6,
   localparam int SLOT_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [KEY_W-1:0]   req_key_code,
   output logic               busy,
   input  logic [COUNT_W-1:0] key_count,
   input  logic [KEY_W-1:0]   key_codes [KEY_SLOTS],
   input  logic               q_full,
   output logic               push,
   output cmd_type            fr_cmd,
   output logic [KEY_W-1:0]   fr_key,
   output logic               fr_hit,
   output logic [SLOT_W-1:0]  fr_slot
);

   logic               fr_valid_ff, fr_valid_in;
   cmd_type            cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic               hit_ff, hit_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] used;
   logic               accept;
   logic               known;

   assign busy   = fr_valid_ff & q_full;
   assign accept = start & ~busy;
   assign push   = fr_valid_ff & ~q_full;
   assign known  = (req_cmd == CMD_PRESS) || (req_cmd == CMD_RELEASE) ||
                   (req_cmd == CMD_TICK);

   // slots in use, capped at the slot count
   assign used = (key_count > COUNT_W'(KEY_SLOTS)) ? COUNT_W'(KEY_SLOTS) : key_count;

   // lowest matching slot in use owns the key
   always_comb begin
      hit_in  = 1'b0;
      slot_in = '0;
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if ((COUNT_W'(i) < used) && (key_codes[i] == req_key_code)) begin
            hit_in  = 1'b1;
            slot_in = SLOT_W'(i);
         end
      end
   end

   // holding stage; unknown kinds are dropped here
   assign fr_valid_in = (fr_valid_ff & ~push) | (accept & known);

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_cmd);
         key_ff  <= req_key_code;
         hit_ff  <= hit_in;
         slot_ff <= slot_in;
      end
   end

   assign fr_cmd  = cmd_ff;
   assign fr_key  = key_ff;
   assign fr_hit  = hit_ff;
   assign fr_slot = slot_ff;

endmodule

/* rtl/krr_queue.sv */
// ----------------------------------------------------------------------------
// krr_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module krr_queue
   import krr_pkg::*;
#(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              q_valid,
   output logic              q_full,
   output logic [DATA_W-1:0] q_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/krr_back.sv */
// ----------------------------------------------------------------------------
// krr_back
// Slot state and result generation. Press and release words are handled in idle;
// a tick walks the slots one per cycle and reports each slot that expires.
// ----------------------------------------------------------------------------
module krr_back
   import krr_pkg::*;
#(
   parameter int KEY_SLOTS = 6,
   localparam int SLOT_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   input  logic [KEY_W-1:0]   q_key,
   input  logic               q_hit,
   input  logic [SLOT_W-1:0]  q_slot,
   output logic               pop,
   input  logic [DELAY_W-1:0] release_delay,
   input  logic [KEY_W-1:0]   key_codes [KEY_SLOTS],
   output logic               rsp_valid,
   output rsp_type            rsp
);

   back_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]    walk_idx_ff, walk_idx_in;
   logic [KEY_SLOTS-1:0] fire_mask_ff, fire_mask_in;
   logic [KEY_SLOTS-1:0] fire_now;
   logic [KEY_SLOTS-1:0] walk_bit;

   phase_type            phase_ff [KEY_SLOTS];
   logic [DELAY_W-1:0]   cd_ff [KEY_SLOTS];
   logic                 slot_we;
   logic [SLOT_W-1:0]    slot_idx;
   phase_type            phase_in;
   logic [DELAY_W-1:0]   cd_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // slots that expire on this tick
   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         fire_now[i] = (phase_ff[i] == PH_PENDING) && (cd_ff[i] <= DELAY_W'(1));
      end
   end

   assign walk_bit = KEY_SLOTS'(1) << walk_idx_ff;

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      walk_idx_in  = walk_idx_ff;
      fire_mask_in = fire_mask_ff;
      pop          = 1'b0;
      slot_we      = 1'b0;
      slot_idx     = q_slot;
      phase_in     = PH_HELD;
      cd_in        = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               unique case (q_cmd)
                  CMD_PRESS: begin
                     slot_we             = q_hit;
                     phase_in            = PH_HELD;
                     cd_in               = '0;
                     rsp_valid_in        = 1'b1;
                     rsp_in.report_press = q_hit && (phase_ff[q_slot] == PH_ABSENT);
                     rsp_in.event_key    = q_key;
                     rsp_in.eaten        = q_hit;
                     rsp_in.last         = 1'b1;
                  end
                  CMD_RELEASE: begin
                     slot_we          = q_hit;
                     phase_in         = PH_PENDING;
                     cd_in            = release_delay;
                     rsp_valid_in     = 1'b1;
                     rsp_in.event_key = q_key;
                     rsp_in.last      = 1'b1;
                  end
                  CMD_TICK: begin
                     fire_mask_in = fire_now;
                     walk_idx_in  = '0;
                     state_in     = BK_WALK;
                  end
                  default: ;
               endcase
            end
         end
         BK_WALK: begin
            // count down or expire the slot under the walk index
            slot_idx = walk_idx_ff;
            slot_we  = (phase_ff[walk_idx_ff] == PH_PENDING);
            if (fire_mask_ff[walk_idx_ff]) begin
               phase_in              = PH_ABSENT;
               cd_in                 = '0;
               fire_mask_in          = fire_mask_ff & ~walk_bit;
               rsp_valid_in          = 1'b1;
               rsp_in.report_release = 1'b1;
               rsp_in.event_key      = key_codes[walk_idx_ff];
               rsp_in.last           = ((fire_mask_ff & ~walk_bit) == '0);
            end else begin
               phase_in = PH_PENDING;
               cd_in    = cd_ff[walk_idx_ff] - 1'b1;
            end
            if (walk_idx_ff == SLOT_W'(KEY_SLOTS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               walk_idx_in = walk_idx_ff + 1'b1;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff  <= walk_idx_in;
      fire_mask_ff <= fire_mask_in;
      rsp_ff       <= rsp_in;
   end

   // slot table, one entry written per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_SLOTS; i++) begin
            phase_ff[i] <= PH_ABSENT;
            cd_ff[i]    <= '0;
         end
      end else if (slot_we) begin
         phase_ff[slot_idx] <= phase_in;
         cd_ff[slot_idx]    <= cd_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/key_repeat_release_debouncer_top.sv */
// ----------------------------------------------------------------------------
// key_repeat_release_debouncer_top
// Hides key auto-repeat for a table of key codes and delays key releases
// by a number of ticks.
//
//   channel   ports                       handshake
//   input     req_cmd, req_key_code       start, busy
//   result    rsp_*                       rsp_valid strobe, one cycle
//   config    csr_index, csr_wdata        csr_we
//
// A press or release word is handled in the idle state of the back end; a tick
// starts the slot walk of the back end over all KEY_SLOTS slots. Between accept
// and the first result lie the front holding stage, the queue and the result register.
// busy rises only when the front stage and the two-entry queue are full.
// Reset is synchronous; all slots return to absent at once.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module key_repeat_release_debouncer_top
   import krr_pkg::*;
#(
   parameter int KEY_SLOTS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [KEY_W-1:0]      req_key_code,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic                  rsp_report_press,
   output logic                  rsp_report_release,
   output logic [KEY_W-1:0]      rsp_event_key,
   output logic                  rsp_eaten,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int ENTRY_W = CMD_W + KEY_W + 1 + SLOT_W;

   logic [DELAY_W-1:0] release_delay;
   logic [COUNT_W-1:0] key_count;
   logic [KEY_W-1:0]   key_codes [KEY_SLOTS];

   logic               q_full, q_valid, push, pop;
   cmd_type            fr_cmd;
   logic [KEY_W-1:0]   fr_key;
   logic               fr_hit;
   logic [SLOT_W-1:0]  fr_slot;
   logic [ENTRY_W-1:0] push_data, q_data;
   rsp_type            rsp;

   krr_csr #(.KEY_SLOTS(KEY_SLOTS)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .release_delay (release_delay),
      .key_count     (key_count),
      .key_codes     (key_codes)
   );

   krr_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_cmd      (req_cmd),
      .req_key_code (req_key_code),
      .busy         (busy),
      .key_count    (key_count),
      .key_codes    (key_codes),
      .q_full       (q_full),
      .push         (push),
      .fr_cmd       (fr_cmd),
      .fr_key       (fr_key),
      .fr_hit       (fr_hit),
      .fr_slot      (fr_slot)
   );

   // queue word: kind, key, hit, slot
   assign push_data = {fr_cmd, fr_key, fr_hit, fr_slot};

   krr_queue #(.DATA_W(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .q_data    (q_data)
   );

   krr_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (cmd_type'(q_data[ENTRY_W-1 -: CMD_W])),
      .q_key         (q_data[ENTRY_W-CMD_W-1 -: KEY_W]),
      .q_hit         (q_data[SLOT_W]),
      .q_slot        (q_data[SLOT_W-1:0]),
      .pop           (pop),
      .release_delay (release_delay),
      .key_codes     (key_codes),
      .rsp_valid     (rsp_valid),
      .rsp           (rsp)
   );

   assign rsp_report_press   = rsp.report_press;
   assign rsp_report_release = rsp.report_release;
   assign rsp_event_key      = rsp.event_key;
   assign rsp_eaten          = rsp.eaten;
   assign rsp_last           = rsp.last;

endmodule

/* rtl/krr_checker.sv */
// ----------------------------------------------------------------------------
// krr_checker
// Port-level checks of the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module krr_checker
   import krr_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_report_press,
   input logic rsp_report_release,
   input logic rsp_eaten,
   input logic rsp_last
);

   // a press and a release are never reported in the same word
   a_press_release_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_report_press && rsp_report_release))
      else $error("press and release reported together");

   // a reported press always belongs to a tracked key
   a_press_eaten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_press) |-> rsp_eaten)
      else $error("press reported for an untracked key");

   // only tick releases come in runs; anything else is a single word
   a_not_last_is_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_report_release && !rsp_eaten))
      else $error("non-final word that is not a release");

   // nothing leaves and nothing blocks right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !busy))
      else $error("activity right after reset");

endmodule

bind key_repeat_release_debouncer_top krr_checker u_krr_checker (
   .clock              (clock),
   .reset              (reset),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_report_press   (rsp_report_press),
   .rsp_report_release (rsp_report_release),
   .rsp_eaten          (rsp_eaten),
   .rsp_last           (rsp_last)
);
